>>> design/fwbc_pkg.sv
// Shared types and constants for the FIFO write-back cache statistics block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fwbc_pkg;

    localparam int LC_W      = 9;   // line count register width
    localparam int SHIFT_W   = 3;   // block shift register width
    localparam int ADDR_W    = 16;  // address port width
    localparam int STAT_W    = 32;  // statistics counter width
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 1'd1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [LC_W-1:0]    LC_RESET    = 9'd256;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd0;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch the accepted word, begin a lookup
        logic scan;    // issue one tag read, compare the previous one
        logic update;  // commit the lookup and load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic found;     // compared line is a valid match
        logic miss_end;  // last line in use compared without a match
        logic out_free;  // output register can take a new word
    } t_stat;

endpackage

>>> design/fwbc_ctrl.sv
// Sequencing state machine for the cache lookup.
// Depends on fwbc_pkg for the command and status structs.
`timescale 1ns / 1ps

module fwbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fwbc_pkg::t_stat i_stat,
    output fwbc_pkg::t_cmd  o_cmd
);
    import fwbc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.found || i_stat.miss_end) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (i_stat.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/fwbc_datapath.sv
// Tag memory, valid/dirty bits, FIFO pointer, statistics counters and output register.
// Depends on fwbc_pkg; driven by fwbc_ctrl through t_cmd / t_stat.
`timescale 1ns / 1ps

module fwbc_datapath #(
    parameter int MAX_LINES = 256,
    parameter int ADDR_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fwbc_pkg::t_cmd                     i_cmd,
    output fwbc_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_valid,
    input  logic [fwbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fwbc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               i_kind,
    input  logic [fwbc_pkg::ADDR_W-1:0]        i_address,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic                               o_wrote_back,
    output logic [fwbc_pkg::STAT_W-1:0]        o_mem_words_read,
    output logic [fwbc_pkg::STAT_W-1:0]        o_mem_words_written,
    output logic [fwbc_pkg::STAT_W-1:0]        o_read_hits,
    output logic [fwbc_pkg::STAT_W-1:0]        o_read_misses,
    output logic [fwbc_pkg::STAT_W-1:0]        o_write_hits,
    output logic [fwbc_pkg::STAT_W-1:0]        o_write_misses
);
    import fwbc_pkg::*;

    localparam int PTR_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int EXT_W = (CNT_W > LC_W) ? CNT_W : LC_W;

    // configuration
    logic [LC_W-1:0]    r_line_count;
    logic [SHIFT_W-1:0] r_block_shift;

    // line state
    logic [TAG_W-1:0]     r_mem [MAX_LINES];
    logic [TAG_W-1:0]     r_rd_data;
    logic [MAX_LINES-1:0] r_valid;
    logic [MAX_LINES-1:0] r_dirty;
    logic [PTR_W-1:0]     r_ptr;
    logic [PTR_W-1:0]     n_ptr;

    // current access
    logic             r_kind;
    logic [TAG_W-1:0] r_block;
    logic [CNT_W-1:0] r_lines;
    logic [CNT_W-1:0] n_lines;
    logic [PTR_W-1:0] r_rd_idx;
    logic [PTR_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_hit;
    logic [PTR_W-1:0] r_hit_idx;

    // statistics and output register
    logic [STAT_W-1:0] r_rd_words;
    logic [STAT_W-1:0] r_wr_words;
    logic [STAT_W-1:0] r_rd_hits;
    logic [STAT_W-1:0] r_rd_misses;
    logic [STAT_W-1:0] r_wr_hits;
    logic [STAT_W-1:0] r_wr_misses;
    logic              r_out_valid;
    logic              r_out_hit;
    logic              r_out_wb;

    logic [EXT_W-1:0]  lc_ext;
    logic [STAT_W-1:0] words;
    logic              match;
    logic              last;
    logic              victim_wb;
    logic              mem_we;

    // 0 acts as 1, anything above the array depth acts as the depth
    always_comb begin
        lc_ext = EXT_W'(r_line_count);
        if (lc_ext == '0) begin
            n_lines = CNT_W'(1);
        end else if (lc_ext > EXT_W'(MAX_LINES)) begin
            n_lines = CNT_W'(MAX_LINES);
        end else begin
            n_lines = lc_ext[CNT_W-1:0];
        end
    end

    assign words     = STAT_W'(1) << r_block_shift;
    assign match     = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_block);
    assign last      = r_cmp_vld && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_lines);
    assign victim_wb = r_valid[r_ptr] && r_dirty[r_ptr];
    assign mem_we    = i_cmd.update && !r_hit;
    assign n_ptr     = ((CNT_W'(r_ptr) + CNT_W'(1)) >= r_lines) ? '0 : r_ptr + PTR_W'(1);

    assign o_stat.found    = i_cmd.scan && match;
    assign o_stat.miss_end = i_cmd.scan && !match && last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // tag store: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
        if (mem_we) begin
            r_mem[r_ptr] <= r_block;
        end
    end

    // per-access payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_kind;
            r_block <= TAG_W'(i_address[TAG_W-1:0] >> r_block_shift);
            r_lines <= n_lines;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx;
            if (match || last) begin
                r_hit     <= match;
                r_hit_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.update) begin
            r_out_hit <= r_hit;
            r_out_wb  <= !r_hit && victim_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count  <= LC_RESET;
            r_block_shift <= SHIFT_RESET;
            r_valid       <= '0;
            r_dirty       <= '0;
            r_ptr         <= '0;
            r_rd_idx      <= '0;
            r_cmp_vld     <= 1'b0;
            r_rd_words    <= '0;
            r_wr_words    <= '0;
            r_rd_hits     <= '0;
            r_rd_misses   <= '0;
            r_wr_hits     <= '0;
            r_wr_misses   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[LC_W-1:0];
                    CFG_BLOCK_SHIFT: r_block_shift <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            r_cmp_vld <= i_cmd.scan;

            if (i_cmd.start) begin
                r_rd_idx <= '0;
                // pointer left past the end by a smaller line count
                if (CNT_W'(r_ptr) >= n_lines) begin
                    r_ptr <= '0;
                end
            end else if (i_cmd.scan) begin
                if ((CNT_W'(r_rd_idx) + CNT_W'(1)) < r_lines) begin
                    r_rd_idx <= r_rd_idx + PTR_W'(1);
                end
            end

            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.update) begin
                if (r_hit) begin
                    if (r_kind == KIND_WRITE) begin
                        r_dirty[r_hit_idx] <= 1'b1;
                        r_wr_hits          <= r_wr_hits + STAT_W'(1);
                    end else begin
                        r_rd_hits <= r_rd_hits + STAT_W'(1);
                    end
                end else begin
                    r_rd_words <= r_rd_words + words;
                    if (victim_wb) begin
                        r_wr_words <= r_wr_words + words;
                    end
                    if (r_kind == KIND_WRITE) begin
                        r_wr_misses <= r_wr_misses + STAT_W'(1);
                    end else begin
                        r_rd_misses <= r_rd_misses + STAT_W'(1);
                    end
                    r_valid[r_ptr] <= 1'b1;
                    r_dirty[r_ptr] <= (r_kind == KIND_WRITE);
                    r_ptr          <= n_ptr;
                end
            end
        end
    end

    // counters only move on update, which waits for a free output register
    assign o_out_valid         = r_out_valid;
    assign o_hit               = r_out_hit;
    assign o_wrote_back        = r_out_wb;
    assign o_mem_words_read    = r_rd_words;
    assign o_mem_words_written = r_wr_words;
    assign o_read_hits         = r_rd_hits;
    assign o_read_misses       = r_rd_misses;
    assign o_write_hits        = r_wr_hits;
    assign o_write_misses      = r_wr_misses;

endmodule

>>> design/fifo_write_back_cache_stats.sv
// An accepted word is scanned against the lines in use (up to MAX_LINES), stopping
// at the first match or after the last line, then waits for a free output register.
// A new word is taken only once the last one has left the scan; the tag compare walks the single
// read port of the tag memory one line per cycle.
// Reset (synchronous, active low) clears valid/dirty bits, FIFO pointer,
// counters and config (line count 256, block shift 0); tags need no clearing.
`timescale 1ns / 1ps

module fifo_write_back_cache_stats #(
    parameter int MAX_LINES = 256,
    parameter int ADDR_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fwbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fwbc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [fwbc_pkg::ADDR_W-1:0]    i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic                           o_wrote_back,
    output logic [fwbc_pkg::STAT_W-1:0]    o_mem_words_read,
    output logic [fwbc_pkg::STAT_W-1:0]    o_mem_words_written,
    output logic [fwbc_pkg::STAT_W-1:0]    o_read_hits,
    output logic [fwbc_pkg::STAT_W-1:0]    o_read_misses,
    output logic [fwbc_pkg::STAT_W-1:0]    o_write_hits,
    output logic [fwbc_pkg::STAT_W-1:0]    o_write_misses
);
    import fwbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    fwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fwbc_datapath #(
        .MAX_LINES (MAX_LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_address           (i_address),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_hit               (o_hit),
        .o_wrote_back        (o_wrote_back),
        .o_mem_words_read    (o_mem_words_read),
        .o_mem_words_written (o_mem_words_written),
        .o_read_hits         (o_read_hits),
        .o_read_misses       (o_read_misses),
        .o_write_hits        (o_write_hits),
        .o_write_misses      (o_write_misses)
    );

endmodule

>>> design/fwbc_checker.sv
// Port-level checks for fifo_write_back_cache_stats, attached by bind.
// Depends on fwbc_pkg for port widths.
`timescale 1ns / 1ps

module fwbc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_hit,
    input logic                        o_wrote_back,
    input logic [fwbc_pkg::STAT_W-1:0] o_mem_words_read
);
    import fwbc_pkg::*;

    // one lookup at a time: no second word right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

    // a write-back only happens on a miss
    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wrote_back) |-> !o_hit)
        else $error("write-back reported on a hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_mem_words_read))
        else $error("output word changed while stalled");

endmodule

bind fifo_write_back_cache_stats fwbc_checker u_fwbc_checker (.*);

>>> test/fwbc_stats_checker.sv
// Scoreboard for the FIFO write-back cache statistics block: tracks config writes,
// predicts one result word per accepted access and compares it against the output channel.
// Depends on fwbc_pkg for widths, register indexes and access kinds.
`timescale 1ns / 1ps

module fwbc_stats_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [fwbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fwbc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic [fwbc_pkg::ADDR_W-1:0]    i_address,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_hit,
    input  logic                           i_wrote_back,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_mem_words_read,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_mem_words_written,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_read_hits,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_read_misses,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_write_hits,
    input  logic [fwbc_pkg::STAT_W-1:0]    i_write_misses,
    output int                             o_errors,
    output int                             o_pending
);
    import fwbc_pkg::*;

    localparam int LINES = 256;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic              hit;
        logic              wrote_back;
        logic [STAT_W-1:0] words_read;
        logic [STAT_W-1:0] words_written;
        logic [STAT_W-1:0] read_hits;
        logic [STAT_W-1:0] read_misses;
        logic [STAT_W-1:0] write_hits;
        logic [STAT_W-1:0] write_misses;
    } t_cache_stats;

    t_cache_stats       stats_expected_q[$];

    logic [LC_W-1:0]    line_count;
    logic [SHIFT_W-1:0] block_shift;
    logic [ADDR_W-1:0]  tag_mem [LINES];
    logic               valid_bits [LINES];
    logic               dirty_bits [LINES];
    int unsigned        victim_ptr;
    logic [STAT_W-1:0]  words_read;
    logic [STAT_W-1:0]  words_written;
    logic [STAT_W-1:0]  rd_hits;
    logic [STAT_W-1:0]  rd_misses;
    logic [STAT_W-1:0]  wr_hits;
    logic [STAT_W-1:0]  wr_misses;
    int                 mismatches = 0;

    assign o_errors = mismatches;

    task automatic reset_cache();
        line_count    = LC_RESET;
        block_shift   = SHIFT_RESET;
        victim_ptr    = 0;
        words_read    = '0;
        words_written = '0;
        rd_hits       = '0;
        rd_misses     = '0;
        wr_hits       = '0;
        wr_misses     = '0;
        for (int i = 0; i < LINES; i++) begin
            valid_bits[i] = 1'b0;
            dirty_bits[i] = 1'b0;
            tag_mem[i]    = '0;
        end
    endtask

    // One access against the shadow cache; updates state and returns the result word.
    task automatic run_access(input logic kind, input logic [ADDR_W-1:0] addr,
                              output t_cache_stats res);
        int unsigned       lines;
        int unsigned       i;
        int unsigned       hit_line;
        logic [ADDR_W-1:0] blk;
        logic [STAT_W-1:0] words;
        logic              found;
        lines = (line_count == 0) ? 1 : ((line_count > LINES) ? LINES : line_count);
        blk   = addr >> block_shift;
        words = 32'd1 << block_shift;
        // pointer left past the lines in use by a smaller line count
        if (victim_ptr >= lines) victim_ptr = 0;
        found    = 1'b0;
        hit_line = 0;
        // lowest matching line wins when tags repeat
        for (i = 0; i < lines && !found; i++) begin
            if (valid_bits[i] && tag_mem[i] == blk) begin
                found    = 1'b1;
                hit_line = i;
            end
        end
        res.hit        = found;
        res.wrote_back = 1'b0;
        if (found) begin
            if (kind == KIND_WRITE) begin
                dirty_bits[hit_line] = 1'b1;
                wr_hits++;
            end else begin
                rd_hits++;
            end
        end else begin
            words_read += words;
            if (kind == KIND_WRITE) wr_misses++;
            else rd_misses++;
            if (valid_bits[victim_ptr] && dirty_bits[victim_ptr]) begin
                words_written += words;
                res.wrote_back = 1'b1;
            end
            valid_bits[victim_ptr] = 1'b1;
            tag_mem[victim_ptr]    = blk;
            dirty_bits[victim_ptr] = (kind == KIND_WRITE);
            victim_ptr = (victim_ptr + 1 >= lines) ? 0 : victim_ptr + 1;
        end
        res.words_read    = words_read;
        res.words_written = words_written;
        res.read_hits     = rd_hits;
        res.read_misses   = rd_misses;
        res.write_hits    = wr_hits;
        res.write_misses  = wr_misses;
    endtask

    task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                               input logic [STAT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_cache_stats exp_word;
        t_cache_stats new_word;
        if (!i_rst_n) begin
            reset_cache();
            stats_expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_COUNT:  line_count  = i_cfg_data[LC_W-1:0];
                    CFG_BLOCK_SHIFT: block_shift = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (stats_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result word with nothing predicted", $realtime);
                end else begin
                    exp_word = stats_expected_q.pop_front();
                    check_field("hit", STAT_W'(exp_word.hit), STAT_W'(i_hit));
                    check_field("wrote_back", STAT_W'(exp_word.wrote_back),
                                STAT_W'(i_wrote_back));
                    check_field("mem_words_read", exp_word.words_read, i_mem_words_read);
                    check_field("mem_words_written", exp_word.words_written,
                                i_mem_words_written);
                    check_field("read_hits", exp_word.read_hits, i_read_hits);
                    check_field("read_misses", exp_word.read_misses, i_read_misses);
                    check_field("write_hits", exp_word.write_hits, i_write_hits);
                    check_field("write_misses", exp_word.write_misses, i_write_misses);
                end
            end
            if (i_in_valid && i_in_ready) begin
                run_access(i_kind, i_address, new_word);
                stats_expected_q.push_back(new_word);
            end
        end
        o_pending = stats_expected_q.size();
    end

endmodule

>>> test/tb_top.sv
// Top of the cache statistics testbench: clock, reset, config writes, access stimulus
// and output back-pressure; the verdict comes from the error count of fwbc_stats_checker.
// Depends on fwbc_pkg, fifo_write_back_cache_stats and fwbc_stats_checker.
`timescale 1ns / 1ps

module tb_top;
    import fwbc_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 acc_kind;
    logic [ADDR_W-1:0]    acc_addr;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic                 wrote_back;
    logic [STAT_W-1:0]    mem_words_read;
    logic [STAT_W-1:0]    mem_words_written;
    logic [STAT_W-1:0]    read_hits;
    logic [STAT_W-1:0]    read_misses;
    logic [STAT_W-1:0]    write_hits;
    logic [STAT_W-1:0]    write_misses;
    int                   err_count;
    int                   pending;
    bit                   calm = 1'b0;

    fifo_write_back_cache_stats dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_kind              (acc_kind),
        .i_address           (acc_addr),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_hit               (hit),
        .o_wrote_back        (wrote_back),
        .o_mem_words_read    (mem_words_read),
        .o_mem_words_written (mem_words_written),
        .o_read_hits         (read_hits),
        .o_read_misses       (read_misses),
        .o_write_hits        (write_hits),
        .o_write_misses      (write_misses)
    );

    fwbc_stats_checker stats_chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_kind              (acc_kind),
        .i_address           (acc_addr),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_hit               (hit),
        .i_wrote_back        (wrote_back),
        .i_mem_words_read    (mem_words_read),
        .i_mem_words_written (mem_words_written),
        .i_read_hits         (read_hits),
        .i_read_misses       (read_misses),
        .i_write_hits        (write_hits),
        .i_write_misses      (write_misses),
        .o_errors            (err_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(99) >= 22);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // All tasks are entered and left at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr);
        while (!calm && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        acc_kind <= kind;
        acc_addr <= addr;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drain every predicted word, then give the block time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        int unsigned       rand_count;
        int unsigned       phase;
        int unsigned       lines;
        int unsigned       n_items;
        int unsigned       pick;
        logic [LC_W-1:0]    cur_lc;
        logic [SHIFT_W-1:0] cur_sh;
        logic [5:0]         junk;
        logic [ADDR_W-1:0]  off_mask;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  addr_pool[$];

        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        acc_kind  = KIND_READ;
        acc_addr  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: address extremes, hits and misses of both kinds
        send_access(KIND_READ,  16'h0000);
        send_access(KIND_READ,  16'h0000);
        send_access(KIND_WRITE, 16'hFFFF);
        send_access(KIND_WRITE, 16'hFFFF);
        send_access(KIND_READ,  16'hFFFF);
        send_access(KIND_WRITE, 16'h0000);
        // zero line count acts as one line; pointer is stale; junk above the shift bits
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd0);
        write_reg(CFG_BLOCK_SHIFT, 9'h1FF);
        send_access(KIND_WRITE, 16'h1234);
        send_access(KIND_READ,  16'h1200);
        send_access(KIND_READ,  16'hFF80);
        // line 1 kept its old tag while out of use
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd2);
        write_reg(CFG_BLOCK_SHIFT, 9'd0);
        send_access(KIND_READ,  16'h01FF);
        send_access(KIND_READ,  16'hFFFF);
        // build two valid lines with the same tag
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd1);
        send_access(KIND_READ,  16'hFFFF);
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd2);
        send_access(KIND_WRITE, 16'hFFFF);
        send_access(KIND_READ,  16'h1234);
        send_access(KIND_READ,  16'hFFFF);
        // line count above the array size
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd511);
        write_reg(CFG_BLOCK_SHIFT, 9'd3);
        send_access(KIND_WRITE, 16'h0007);
        send_access(KIND_READ,  16'h0000);
        send_access(KIND_WRITE, 16'hFFF8);
        send_access(KIND_READ,  16'hFFFF);
        wait_idle();
        write_reg(CFG_LINE_COUNT, 9'd300);
        send_access(KIND_READ,  16'h7FFF);
        send_access(KIND_WRITE, 16'h8000);
        cur_lc = 9'd300;
        cur_sh = 3'd3;

        rand_count = 0;
        phase      = 0;
        while (rand_count < RANDOM_ITEMS) begin
            wait_idle();
            calm <= (phase >= 4 && phase < 7);
            pick = $urandom_range(99);
            if (pick < 55)      cur_lc = LC_W'($urandom_range(1, 8));
            else if (pick < 75) cur_lc = LC_W'($urandom_range(9, 40));
            else if (pick < 82) cur_lc = '0;
            else if (pick < 88) cur_lc = LC_W'($urandom_range(257, 511));
            else if (pick < 92) cur_lc = 9'd256;
            else                cur_lc = LC_W'($urandom_range(41, 255));
            pick = $urandom_range(99);
            if (pick < 20)      cur_sh = 3'd0;
            else if (pick < 40) cur_sh = 3'd7;
            else                cur_sh = SHIFT_W'($urandom_range(0, 7));
            junk = 6'($urandom);
            // sometimes only one register changes, the other one carries over
            case ($urandom_range(0, 3))
                0: write_reg(CFG_LINE_COUNT, cur_lc);
                1: write_reg(CFG_BLOCK_SHIFT, {junk, cur_sh});
                2: begin
                    write_reg(CFG_LINE_COUNT, cur_lc);
                    write_reg(CFG_BLOCK_SHIFT, {junk, cur_sh});
                end
                default: begin
                    write_reg(CFG_BLOCK_SHIFT, {junk, cur_sh});
                    write_reg(CFG_LINE_COUNT, cur_lc);
                end
            endcase
            cur_lc   = stats_chk.line_count;
            cur_sh   = stats_chk.block_shift;
            lines    = (cur_lc == 0) ? 1 : ((cur_lc > 256) ? 256 : cur_lc);
            off_mask = (16'd1 << cur_sh) - 16'd1;
            // working set a bit larger than the cache so hits and evictions both happen
            addr_pool.delete();
            repeat (lines + $urandom_range(1, lines / 2 + 2))
                addr_pool.push_back(ADDR_W'($urandom_range(0, 65535)));
            n_items = (lines > 64) ? $urandom_range(6, 14) : $urandom_range(15, 40);
            repeat (n_items) begin
                if ($urandom_range(99) < 72) begin
                    addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                    addr = (addr & ~off_mask) | (ADDR_W'($urandom_range(0, 65535)) & off_mask);
                end else begin
                    addr = ADDR_W'($urandom_range(0, 65535));
                end
                send_access(1'($urandom_range(0, 1)), addr);
                rand_count++;
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
design/fwbc_pkg.sv
design/fwbc_ctrl.sv
design/fwbc_datapath.sv
design/fifo_write_back_cache_stats.sv
design/fwbc_checker.sv
test/fwbc_stats_checker.sv
test/tb_top.sv
